/* sv/pobp_pkg.sv */
// Shared types, constants and helper functions of the pulse oximeter beat processor.
package pobp_pkg;

    localparam int STATE_W    = 40;
    localparam int ACC_W      = 66;
    localparam int MUL_W      = 26;
    localparam int DIV_W      = 64;
    localparam int DIV_CNT_W  = 7;
    localparam int COEF_SHIFT = 20;
    localparam int REDUCED_W  = 26;
    localparam int SLOT_W     = 16;
    localparam int OUT_W      = 24;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_W       = 18;

    localparam int DEFAULT_AVERAGE_DEPTH = 5;
    localparam int DEFAULT_SAMPLE_BITS   = 18;
    localparam int DEFAULT_FRACTION_BITS = 16;

    // 2^30 / 3.48311
    localparam logic [28:0] SCALE_Q30 = 29'd308271006;

    // Feedback taps in Q20, oldest output first. COEF_SUB marks the subtracted taps.
    localparam logic [MUL_W-1:0] COEF [4] = '{26'd180158, 26'd386573, 26'd1228734, 26'd2069683};
    localparam logic [3:0] COEF_SUB = 4'b0101;

    localparam logic [15:0] RESET_PEAK_THRESHOLD = 16'd100;
    localparam logic [15:0] RESET_MIN_INTERVAL   = 16'd50;
    localparam logic [11:0] RESET_SAMPLE_RATE    = 12'd100;
    localparam logic [7:0]  RESET_HR_MIN         = 8'd40;
    localparam logic [7:0]  RESET_HR_MAX         = 8'd150;
    localparam logic [6:0]  RESET_SPO2_MIN       = 7'd50;
    localparam logic [6:0]  RESET_SPO2_MAX       = 7'd101;
    localparam logic [11:0] RESET_RATE_AVERAGE   = 12'd992;
    localparam logic [10:0] RESET_OXY_AVERAGE    = 11'd992;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PEAK_THRESHOLD = 3'd0,
        REG_MIN_INTERVAL   = 3'd1,
        REG_SAMPLE_RATE    = 3'd2,
        REG_HR_MIN         = 3'd3,
        REG_HR_MAX         = 3'd4,
        REG_SPO2_MIN       = 3'd5,
        REG_SPO2_MAX       = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic load;
        logic start;
        logic sub;
    } mac_cmd_t;

    function automatic logic [ACC_W-1:0] sext_state(input logic [STATE_W-1:0] v);
        return {{(ACC_W-STATE_W){v[STATE_W-1]}}, v};
    endfunction

    function automatic logic [STATE_W-1:0] sat_state(input logic [ACC_W-1:0] v);
        logic [ACC_W-STATE_W:0] top;
        top = v[ACC_W-1:STATE_W-1];
        if ((top == '0) || (top == '1))
            return v[STATE_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(STATE_W-1){1'b0}}};
        else
            return {1'b0, {(STATE_W-1){1'b1}}};
    endfunction

    // Feed-forward part of the band-pass, pre-scaled to Q20 and with the rounding half added.
    function automatic logic [ACC_W-1:0] filt_init(input logic [STATE_W-1:0] x0,
                                                   input logic [STATE_W-1:0] x2,
                                                   input logic [STATE_W-1:0] x4);
        logic [ACC_W-1:0] s;
        s = sext_state(x0) + sext_state(x4) - (sext_state(x2) << 1);
        return (s << COEF_SHIFT) + (ACC_W'(1) << (COEF_SHIFT - 1));
    endfunction

endpackage

/* sv/pulse_oximeter_beat_processor.sv */
// Pulse oximeter beat processor: band-pass of red and IR, beat detection, rate and SpO2.
// One item at a time. Without a beat, the time from accept to the next accept is set by the
// bit-serial MACs: the 18 sample bits and the 79 coefficient bits, one bit per cycle, plus
// control steps. A beat adds the heart rate and SpO2 work, mostly the serial divider.
// A finished result waits in the output register while the next item runs. Reset clears
// histories, indexes and slot rings, loads register defaults and sets both averages to 99.2.
module pulse_oximeter_beat_processor #(
    parameter int AVERAGE_DEPTH = pobp_pkg::DEFAULT_AVERAGE_DEPTH,
    parameter int SAMPLE_BITS   = pobp_pkg::DEFAULT_SAMPLE_BITS,
    parameter int FRACTION_BITS = pobp_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic [pobp_pkg::IN_W-1:0]          red_sample,
    input  logic [pobp_pkg::IN_W-1:0]          ir_sample,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [pobp_pkg::OUT_W-1:0]  red_filtered,
    output logic signed [pobp_pkg::OUT_W-1:0]  ir_filtered,
    output logic                               beat_found,
    output logic [11:0]                        heart_rate_tenths,
    output logic [10:0]                        spo2_tenths,
    input  logic                               cfg_write,
    input  logic [pobp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pobp_pkg::CFG_W-1:0]         cfg_data
);

    localparam int D         = AVERAGE_DEPTH;
    localparam int PTR_W     = (D > 1) ? $clog2(D) : 1;
    localparam int SUM_W     = 16 + $clog2(D) + 1;
    localparam int SCALE_SH  = 30 - FRACTION_BITS;
    localparam int RED_SH    = FRACTION_BITS - 8;
    localparam int MASK_BITS = (SAMPLE_BITS < pobp_pkg::IN_W) ? SAMPLE_BITS : pobp_pkg::IN_W;
    localparam int SW        = pobp_pkg::STATE_W;
    localparam int AW        = pobp_pkg::ACC_W;
    localparam int DW        = pobp_pkg::DIV_W;
    localparam int HR_NUM_W  = 33;
    localparam int Q_NUM_W   = 60;

    localparam logic [pobp_pkg::IN_W-1:0] SAMPLE_MASK =
        {pobp_pkg::IN_W{1'b1}} >> (pobp_pkg::IN_W - MASK_BITS);
    localparam logic [pobp_pkg::MUL_W-1:0] SPO2_GAIN = 26'd250;
    localparam logic [DW-1:0] SPO2_BASE  = 64'd1100;
    localparam logic [DW-1:0] SPO2_LOW_Q = 64'd100;
    localparam logic [15:0]   SPO2_CAP   = 16'd999;
    localparam logic [pobp_pkg::REDUCED_W-1:0] REDUCED_MAX = '1;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_SCALE = 14'b00000000000010,
        S_LOAD  = 14'b00000000000100,
        S_TERM  = 14'b00000000001000,
        S_TWAIT = 14'b00000000010000,
        S_BEAT  = 14'b00000000100000,
        S_HRW   = 14'b00000001000000,
        S_QMUL  = 14'b00000010000000,
        S_QDIV  = 14'b00000100000000,
        S_SUM   = 14'b00001000000000,
        S_AVGR  = 14'b00010000000000,
        S_AVGRW = 14'b00100000000000,
        S_AVGOW = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] peak_threshold_reg, min_interval_reg;
    logic [11:0] sample_rate_reg;
    logic [7:0]  hr_min_reg, hr_max_reg;
    logic [6:0]  spo2_min_reg, spo2_max_reg;

    // filter histories, index 4 newest
    logic signed [SW-1:0] red_x_reg [5];
    logic signed [SW-1:0] red_y_reg [5];
    logic signed [SW-1:0] ir_x_reg  [5];
    logic signed [SW-1:0] ir_y_reg  [5];

    logic [1:0]  tap_reg;
    logic [31:0] sample_index_reg, last_beat_reg;
    logic [pobp_pkg::SLOT_W-1:0] rate_slot_reg [D];
    logic [pobp_pkg::SLOT_W-1:0] oxy_slot_reg  [D];
    logic [PTR_W-1:0] ptr_reg, sum_idx_reg;
    logic [11:0] rate_avg_reg;
    logic [10:0] oxy_avg_reg;
    logic [SUM_W-1:0] rate_sum_reg, oxy_sum_reg;
    logic same_reg, beat_reg;
    logic result_valid_reg, result_valid_next;
    logic signed [pobp_pkg::OUT_W-1:0] red_filtered_reg, ir_filtered_reg;
    logic beat_found_reg;
    logic [11:0] heart_rate_reg;
    logic [10:0] spo2_reg;

    // datapath units
    pobp_pkg::mac_cmd_t red_cmd, ir_cmd;
    logic [AW-1:0] red_load, ir_load, red_mcand, ir_mcand, red_acc, ir_acc;
    logic [pobp_pkg::MUL_W-1:0] red_mult, ir_mult;
    logic red_busy, ir_busy, macs_busy;
    logic div_start, div_busy;
    logic [DW-1:0] div_num, div_den, div_quot;
    logic [pobp_pkg::DIV_CNT_W-1:0] div_steps;

    logic [pobp_pkg::IN_W-1:0] red_masked, ir_masked;
    logic [AW-1:0] red_scaled, ir_scaled, red_filt, ir_filt;
    logic [31:0] interval;
    logic [41:0] depth, depth_sum;
    logic beat;
    logic [HR_NUM_W-1:0] hr_num;
    logic [pobp_pkg::SLOT_W-1:0] hr_slot, spo2_value;
    logic [DW-1:0] rate_avg_value, oxy_avg_value;
    logic load_out;

    function automatic logic [pobp_pkg::REDUCED_W-1:0] reduce(input logic [SW-1:0] v);
        logic [SW-1:0] mag;
        mag = v[SW-1] ? (~v + 1'b1) : v;
        mag = mag >> RED_SH;
        if (mag > SW'(REDUCED_MAX))
            return REDUCED_MAX;
        else
            return mag[pobp_pkg::REDUCED_W-1:0];
    endfunction

    // Negated value, truncated toward zero to an integer and saturated to 24 bits.
    function automatic logic [pobp_pkg::OUT_W-1:0] inv_int(input logic [SW-1:0] y);
        logic [SW:0] mag;
        logic [SW:0] ip;
        mag = y[SW-1] ? ({1'b0, ~y} + 1'b1) : {1'b0, y};
        ip  = mag >> FRACTION_BITS;
        if (y[SW-1])
            return (ip > (SW+1)'(24'h7FFFFF)) ? 24'h7FFFFF : ip[23:0];
        else
            return (ip > (SW+1)'(24'h800000)) ? 24'h800000 : (~ip[23:0] + 1'b1);
    endfunction

    function automatic logic [DW-1:0] range_check(input logic [DW-1:0] avg,
                                                  input logic [7:0] lo,
                                                  input logic [7:0] hi);
        logic [DW-1:0] lo10;
        logic [DW-1:0] hi10;
        lo10 = DW'(lo) * DW'(10);
        hi10 = DW'(hi) * DW'(10);
        if ((avg < lo10) || (avg > hi10))
            return '0;
        else
            return avg;
    endfunction

    pobp_mac u_red_mac (
        .clk(clk), .rst_n(rst_n), .cmd(red_cmd), .load_value(red_load),
        .mcand(red_mcand), .mult(red_mult), .acc(red_acc), .busy(red_busy)
    );

    pobp_mac u_ir_mac (
        .clk(clk), .rst_n(rst_n), .cmd(ir_cmd), .load_value(ir_load),
        .mcand(ir_mcand), .mult(ir_mult), .acc(ir_acc), .busy(ir_busy)
    );

    pobp_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .steps(div_steps), .quot(div_quot), .busy(div_busy)
    );

    assign macs_busy  = red_busy | ir_busy;
    assign red_masked = red_sample & SAMPLE_MASK;
    assign ir_masked  = ir_sample & SAMPLE_MASK;
    assign red_scaled = AW'($signed(red_acc) >>> SCALE_SH);
    assign ir_scaled  = AW'($signed(ir_acc) >>> SCALE_SH);
    assign red_filt   = AW'($signed(red_acc) >>> pobp_pkg::COEF_SHIFT);
    assign ir_filt    = AW'($signed(ir_acc) >>> pobp_pkg::COEF_SHIFT);

    assign interval  = sample_index_reg - last_beat_reg;
    assign depth     = 42'(peak_threshold_reg) << FRACTION_BITS;
    assign depth_sum = {{2{ir_y_reg[4][SW-1]}}, ir_y_reg[4]} + depth;
    // The newest inverted IR must reach the threshold and the inverted IR two back must be a peak.
    assign beat = (depth_sum[41] || (depth_sum == '0))
               && (ir_y_reg[2] < ir_y_reg[0])
               && (ir_y_reg[2] < ir_y_reg[4])
               && (interval > 32'(min_interval_reg));
    assign hr_num = HR_NUM_W'(sample_rate_reg) * HR_NUM_W'(600)
                  + HR_NUM_W'(interval >> 1);
    assign hr_slot = (div_quot > DW'(16'hFFFF)) ? 16'hFFFF : div_quot[15:0];

    always_comb
    begin
        if (!same_reg || (div_quot < SPO2_LOW_Q))
            spo2_value = SPO2_CAP;
        else if (div_quot >= SPO2_BASE)
            spo2_value = '0;
        else
            spo2_value = 16'(SPO2_BASE - div_quot);
    end

    assign rate_avg_value = range_check(div_quot, hr_min_reg, hr_max_reg);
    assign oxy_avg_value  = range_check(div_quot, {1'b0, spo2_min_reg}, {1'b0, spo2_max_reg});
    assign load_out = (state_reg == S_DONE) && (!result_valid_reg || !result_stall);
    assign result_valid_next = load_out || (result_valid_reg && result_stall);

    always_comb
    begin
        state_next = state_reg;
        red_cmd    = '0;
        ir_cmd     = '0;
        red_load   = '0;
        ir_load    = '0;
        red_mcand  = '0;
        ir_mcand   = '0;
        red_mult   = '0;
        ir_mult    = '0;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        div_steps  = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    red_cmd    = '{load: 1'b1, start: 1'b1, sub: 1'b0};
                    ir_cmd     = red_cmd;
                    red_load   = AW'(1) << (SCALE_SH - 1);
                    ir_load    = red_load;
                    red_mcand  = AW'(pobp_pkg::SCALE_Q30);
                    ir_mcand   = red_mcand;
                    red_mult   = pobp_pkg::MUL_W'(red_masked);
                    ir_mult    = pobp_pkg::MUL_W'(ir_masked);
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (!macs_busy)
                    state_next = S_LOAD;
            end
            S_LOAD, S_TERM:
            begin
                red_cmd   = '{load: (state_reg == S_LOAD), start: 1'b1,
                              sub: pobp_pkg::COEF_SUB[tap_reg]};
                ir_cmd    = red_cmd;
                red_load  = pobp_pkg::filt_init(red_x_reg[0], red_x_reg[2], red_x_reg[4]);
                ir_load   = pobp_pkg::filt_init(ir_x_reg[0], ir_x_reg[2], ir_x_reg[4]);
                red_mcand = pobp_pkg::sext_state(red_y_reg[tap_reg]);
                ir_mcand  = pobp_pkg::sext_state(ir_y_reg[tap_reg]);
                red_mult  = pobp_pkg::COEF[tap_reg];
                ir_mult   = pobp_pkg::COEF[tap_reg];
                state_next = S_TWAIT;
            end
            S_TWAIT:
            begin
                if (!macs_busy)
                    state_next = (tap_reg == 2'd3) ? S_BEAT : S_TERM;
            end
            S_BEAT:
            begin
                if (beat)
                begin
                    div_start = 1'b1;
                    div_num   = {hr_num, {(DW-HR_NUM_W){1'b0}}};
                    div_den   = DW'(interval);
                    div_steps = pobp_pkg::DIV_CNT_W'(HR_NUM_W);
                    red_cmd   = '{load: 1'b1, start: 1'b1, sub: 1'b0};
                    ir_cmd    = red_cmd;
                    red_mcand = AW'(reduce(red_y_reg[4]));
                    red_mult  = reduce(ir_x_reg[4]);
                    ir_mcand  = AW'(reduce(red_x_reg[4]));
                    ir_mult   = reduce(ir_y_reg[4]);
                    state_next = S_HRW;
                end
                else
                    state_next = S_DONE;
            end
            S_HRW:
            begin
                if (!div_busy && !macs_busy)
                begin
                    if (ir_acc == '0)
                        state_next = S_SUM;
                    else
                    begin
                        // Numerator times 250, with half the divisor added for rounding.
                        red_cmd    = '{load: 1'b1, start: 1'b1, sub: 1'b0};
                        red_load   = ir_acc >> 1;
                        red_mcand  = red_acc;
                        red_mult   = SPO2_GAIN;
                        state_next = S_QMUL;
                    end
                end
            end
            S_QMUL:
            begin
                if (!red_busy)
                begin
                    div_start  = 1'b1;
                    div_num    = {red_acc[Q_NUM_W-1:0], {(DW-Q_NUM_W){1'b0}}};
                    div_den    = ir_acc[DW-1:0];
                    div_steps  = pobp_pkg::DIV_CNT_W'(Q_NUM_W);
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                if (!div_busy)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                if (sum_idx_reg == PTR_W'(D - 1))
                    state_next = S_AVGR;
            end
            S_AVGR:
            begin
                div_start  = 1'b1;
                div_num    = {rate_sum_reg + SUM_W'(D / 2), {(DW-SUM_W){1'b0}}};
                div_den    = DW'(D);
                div_steps  = pobp_pkg::DIV_CNT_W'(SUM_W);
                state_next = S_AVGRW;
            end
            S_AVGRW:
            begin
                if (!div_busy)
                begin
                    div_start  = 1'b1;
                    div_num    = {oxy_sum_reg + SUM_W'(D / 2), {(DW-SUM_W){1'b0}}};
                    div_den    = DW'(D);
                    div_steps  = pobp_pkg::DIV_CNT_W'(SUM_W);
                    state_next = S_AVGOW;
                end
            end
            S_AVGOW:
            begin
                if (!div_busy)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            peak_threshold_reg <= pobp_pkg::RESET_PEAK_THRESHOLD;
            min_interval_reg   <= pobp_pkg::RESET_MIN_INTERVAL;
            sample_rate_reg    <= pobp_pkg::RESET_SAMPLE_RATE;
            hr_min_reg         <= pobp_pkg::RESET_HR_MIN;
            hr_max_reg         <= pobp_pkg::RESET_HR_MAX;
            spo2_min_reg       <= pobp_pkg::RESET_SPO2_MIN;
            spo2_max_reg       <= pobp_pkg::RESET_SPO2_MAX;
            for (int k = 0; k < 5; k++)
            begin
                red_x_reg[k] <= '0;
                red_y_reg[k] <= '0;
                ir_x_reg[k]  <= '0;
                ir_y_reg[k]  <= '0;
            end
            for (int k = 0; k < D; k++)
            begin
                rate_slot_reg[k] <= '0;
                oxy_slot_reg[k]  <= '0;
            end
            tap_reg          <= '0;
            sample_index_reg <= '0;
            last_beat_reg    <= '0;
            ptr_reg          <= '0;
            sum_idx_reg      <= '0;
            rate_avg_reg     <= pobp_pkg::RESET_RATE_AVERAGE;
            oxy_avg_reg      <= pobp_pkg::RESET_OXY_AVERAGE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (cfg_write)
            begin
                case (pobp_pkg::reg_index_t'(cfg_index))
                    pobp_pkg::REG_PEAK_THRESHOLD: peak_threshold_reg <= cfg_data;
                    pobp_pkg::REG_MIN_INTERVAL:   min_interval_reg   <= cfg_data;
                    pobp_pkg::REG_SAMPLE_RATE:    sample_rate_reg    <= cfg_data[11:0];
                    pobp_pkg::REG_HR_MIN:         hr_min_reg         <= cfg_data[7:0];
                    pobp_pkg::REG_HR_MAX:         hr_max_reg         <= cfg_data[7:0];
                    pobp_pkg::REG_SPO2_MIN:       spo2_min_reg       <= cfg_data[6:0];
                    pobp_pkg::REG_SPO2_MAX:       spo2_max_reg       <= cfg_data[6:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (sample_valid)
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            red_x_reg[k] <= red_x_reg[k+1];
                            red_y_reg[k] <= red_y_reg[k+1];
                            ir_x_reg[k]  <= ir_x_reg[k+1];
                            ir_y_reg[k]  <= ir_y_reg[k+1];
                        end
                        tap_reg <= '0;
                    end
                end
                S_SCALE:
                begin
                    if (!macs_busy)
                    begin
                        red_x_reg[4] <= pobp_pkg::sat_state(red_scaled);
                        ir_x_reg[4]  <= pobp_pkg::sat_state(ir_scaled);
                    end
                end
                S_TWAIT:
                begin
                    if (!macs_busy)
                    begin
                        if (tap_reg == 2'd3)
                        begin
                            red_y_reg[4] <= pobp_pkg::sat_state(red_filt);
                            ir_y_reg[4]  <= pobp_pkg::sat_state(ir_filt);
                        end
                        else
                            tap_reg <= tap_reg + 1'b1;
                    end
                end
                S_BEAT:
                begin
                    sample_index_reg <= sample_index_reg + 1'b1;
                    if (beat)
                        last_beat_reg <= sample_index_reg;
                end
                S_HRW:
                begin
                    if (!div_busy && !macs_busy)
                    begin
                        rate_slot_reg[ptr_reg] <= hr_slot;
                        if (ir_acc == '0)
                            oxy_slot_reg[ptr_reg] <= '0;
                        sum_idx_reg <= '0;
                    end
                end
                S_QDIV:
                begin
                    if (!div_busy)
                        oxy_slot_reg[ptr_reg] <= spo2_value;
                    sum_idx_reg <= '0;
                end
                S_SUM:
                begin
                    if (sum_idx_reg != PTR_W'(D - 1))
                        sum_idx_reg <= sum_idx_reg + 1'b1;
                end
                S_AVGRW:
                begin
                    if (!div_busy)
                        rate_avg_reg <= rate_avg_value[11:0];
                end
                S_AVGOW:
                begin
                    if (!div_busy)
                    begin
                        oxy_avg_reg <= oxy_avg_value[10:0];
                        ptr_reg <= (ptr_reg == PTR_W'(D - 1)) ? '0 : ptr_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_BEAT:
            begin
                same_reg <= ~(red_y_reg[4][SW-1] ^ ir_y_reg[4][SW-1]);
                beat_reg <= beat;
            end
            S_HRW, S_QDIV:
            begin
                rate_sum_reg <= '0;
                oxy_sum_reg  <= '0;
            end
            S_SUM:
            begin
                rate_sum_reg <= rate_sum_reg + SUM_W'(rate_slot_reg[sum_idx_reg]);
                oxy_sum_reg  <= oxy_sum_reg + SUM_W'(oxy_slot_reg[sum_idx_reg]);
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    red_filtered_reg <= inv_int(red_y_reg[4]);
                    ir_filtered_reg  <= inv_int(ir_y_reg[4]);
                    beat_found_reg   <= beat_reg;
                    heart_rate_reg   <= rate_avg_reg;
                    spo2_reg         <= oxy_avg_reg;
                end
            end
            default: ;
        endcase
    end

    assign sample_stall      = (state_reg != S_IDLE);
    assign result_valid      = result_valid_reg;
    assign red_filtered      = red_filtered_reg;
    assign ir_filtered       = ir_filtered_reg;
    assign beat_found        = beat_found_reg;
    assign heart_rate_tenths = heart_rate_reg;
    assign spo2_tenths       = spo2_reg;

endmodule

/* sv/pobp_mac.sv */
// Bit-serial multiply-accumulate unit: one multiplier bit per cycle.
module pobp_mac (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pobp_pkg::mac_cmd_t          cmd,
    input  logic [pobp_pkg::ACC_W-1:0]  load_value,
    input  logic [pobp_pkg::ACC_W-1:0]  mcand,
    input  logic [pobp_pkg::MUL_W-1:0]  mult,
    output logic [pobp_pkg::ACC_W-1:0]  acc,
    output logic                        busy
);

    logic [pobp_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [pobp_pkg::ACC_W-1:0] mcand_reg, mcand_next;
    logic [pobp_pkg::MUL_W-1:0] mult_reg, mult_next;
    logic                       sub_reg, sub_next;

    always_comb
    begin
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        sub_next   = sub_reg;
        if (mult_reg != '0)
        begin
            if (mult_reg[0])
                acc_next = sub_reg ? acc_reg - mcand_reg : acc_reg + mcand_reg;
            mcand_next = mcand_reg << 1;
            mult_next  = mult_reg >> 1;
        end
        if (cmd.load)
            acc_next = load_value;
        if (cmd.start)
        begin
            mcand_next = mcand;
            mult_next  = mult;
            sub_next   = cmd.sub;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mult_reg <= '0;
        else
            mult_reg <= mult_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        sub_reg   <= sub_next;
    end

    assign acc  = acc_reg;
    assign busy = (mult_reg != '0);

endmodule

/* sv/pobp_div.sv */
// Restoring serial divider: one quotient bit per cycle, numerator given left-aligned.
module pobp_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pobp_pkg::DIV_W-1:0]      num,
    input  logic [pobp_pkg::DIV_W-1:0]      den,
    input  logic [pobp_pkg::DIV_CNT_W-1:0]  steps,
    output logic [pobp_pkg::DIV_W-1:0]      quot,
    output logic                            busy
);

    logic [pobp_pkg::DIV_W-1:0]     num_reg, num_next;
    logic [pobp_pkg::DIV_W-1:0]     den_reg, den_next;
    logic [pobp_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [pobp_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [pobp_pkg::DIV_W:0]       shifted;
    logic [pobp_pkg::DIV_W+1:0]     diff;
    logic                           ge;

    always_comb
    begin
        shifted  = {rem_reg, num_reg[pobp_pkg::DIV_W-1]};
        diff     = {1'b0, shifted} - {2'b00, den_reg};
        ge       = ~diff[pobp_pkg::DIV_W+1];
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (cnt_reg != '0)
        begin
            rem_next = ge ? diff[pobp_pkg::DIV_W-1:0] : shifted[pobp_pkg::DIV_W-1:0];
            num_next = {num_reg[pobp_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
        end
        if (start)
        begin
            num_next = num;
            den_next = den;
            rem_next = '0;
            cnt_next = steps;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign quot = num_reg;
    assign busy = (cnt_reg != '0);

endmodule

/* bench/pulse_oximeter_beat_processor_tb.sv */
// Self-checking testbench of the pulse oximeter beat processor with a bit-exact predictor.
module pulse_oximeter_beat_processor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [71:0] wide_t;

    typedef struct {
        logic signed [23:0] red;
        logic signed [23:0] ir;
        logic               beat;
        logic [11:0]        rate;
        logic [10:0]        oxygen;
    } reading_t;

    localparam wide_t STATE_TOP = 72'sd549755813887;
    localparam wide_t STATE_BOT = -72'sd549755813888;
    localparam int    STALL_LIMIT = 20000;
    localparam int    SETTLE_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic sample_valid;
    logic sample_stall;
    logic [pobp_pkg::IN_W-1:0] red_sample;
    logic [pobp_pkg::IN_W-1:0] ir_sample;
    logic result_valid;
    logic result_stall;
    logic signed [pobp_pkg::OUT_W-1:0] red_filtered;
    logic signed [pobp_pkg::OUT_W-1:0] ir_filtered;
    logic beat_found;
    logic [11:0] heart_rate_tenths;
    logic [10:0] spo2_tenths;
    logic cfg_write;
    logic [pobp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pobp_pkg::CFG_W-1:0] cfg_data;

    pulse_oximeter_beat_processor uut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall),
        .red_sample(red_sample), .ir_sample(ir_sample),
        .result_valid(result_valid), .result_stall(result_stall),
        .red_filtered(red_filtered), .ir_filtered(ir_filtered),
        .beat_found(beat_found), .heart_rate_tenths(heart_rate_tenths),
        .spo2_tenths(spo2_tenths),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor copy of the registers and state; channel 0 is red, channel 1 is IR.
    logic [15:0] m_threshold, m_min_interval;
    logic [11:0] m_rate_hz;
    logic [7:0]  m_hr_min, m_hr_max;
    logic [6:0]  m_spo2_min, m_spo2_max;
    logic signed [39:0] x_hist [2][5];
    logic signed [39:0] y_hist [2][5];
    logic [31:0] m_index, m_last_beat;
    logic [15:0] m_rate_slot [5];
    logic [15:0] m_oxy_slot [5];
    int          m_pointer;
    logic [11:0] m_rate_avg;
    logic [10:0] m_oxy_avg;

    reading_t expected_readings[$];
    int mismatches = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int hold_request = 0;
    int quiet_cycles = 0;

    function automatic wide_t round_shift(wide_t v, int s);
        return (v + (wide_t'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [39:0] sat40(wide_t v);
        if (v > STATE_TOP)
            return STATE_TOP[39:0];
        if (v < STATE_BOT)
            return STATE_BOT[39:0];
        return v[39:0];
    endfunction

    function automatic logic signed [39:0] filter_step(int ch, logic [17:0] raw);
        wide_t sv;
        wide_t x0, x2, x4, y0, y1, y2, y3, acc;
        for (int k = 0; k < 4; k++)
        begin
            x_hist[ch][k] = x_hist[ch][k + 1];
            y_hist[ch][k] = y_hist[ch][k + 1];
        end
        sv = 0;
        sv[17:0] = raw;
        x_hist[ch][4] = sat40(round_shift(sv * 72'sd308271006, 14));
        x0 = x_hist[ch][0]; x2 = x_hist[ch][2]; x4 = x_hist[ch][4];
        y0 = y_hist[ch][0]; y1 = y_hist[ch][1]; y2 = y_hist[ch][2]; y3 = y_hist[ch][3];
        acc = (x0 + x4 - 2 * x2) * 72'sd1048576 - 72'sd180158 * y0 + 72'sd386573 * y1
            - 72'sd1228734 * y2 + 72'sd2069683 * y3;
        y_hist[ch][4] = sat40(round_shift(acc, 20));
        return y_hist[ch][4];
    endfunction

    function automatic logic signed [23:0] negated_integer(logic signed [39:0] y);
        wide_t v, r;
        v = y;
        v = -v;
        r = (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
        if (r > 72'sd8388607)
            r = 72'sd8388607;
        if (r < -72'sd8388608)
            r = -72'sd8388608;
        return r[23:0];
    endfunction

    function automatic logic [63:0] reduced(logic signed [39:0] v);
        wide_t m;
        m = v;
        if (m < 0)
            m = -m;
        m = m >>> 8;
        if (m > 72'sd67108863)
            m = 72'sd67108863;
        return m[63:0];
    endfunction

    function automatic logic [15:0] oxygen_estimate();
        logic [63:0] num, den, q;
        longint s;
        logic same;
        num = reduced(y_hist[0][4]) * reduced(x_hist[1][4]);
        den = reduced(x_hist[0][4]) * reduced(y_hist[1][4]);
        same = (y_hist[0][4] < 0) == (y_hist[1][4] < 0);
        if (den == 0)
            return 16'd0;
        q = (64'd250 * num + den / 2) / den;
        if (q > 64'd100000)
            q = 64'd100000;
        s = same ? 1100 - longint'(q) : 1100 + longint'(q);
        if (s > 1000)
            s = 999;
        if (s < 0)
            s = 0;
        return s[15:0];
    endfunction

    function automatic logic [31:0] slot_mean(logic [15:0] slots [5], logic [31:0] lo,
                                              logic [31:0] hi);
        logic [31:0] sum, avg;
        sum = 0;
        for (int k = 0; k < 5; k++)
            sum += 32'(slots[k]);
        avg = (sum + 2) / 5;
        if (avg < lo * 10 || avg > hi * 10)
            return 0;
        return avg;
    endfunction

    function automatic void predictor_reset();
        m_threshold = 100; m_min_interval = 50; m_rate_hz = 100;
        m_hr_min = 40; m_hr_max = 150; m_spo2_min = 50; m_spo2_max = 101;
        for (int k = 0; k < 5; k++)
        begin
            for (int c = 0; c < 2; c++)
            begin
                x_hist[c][k] = 0;
                y_hist[c][k] = 0;
            end
            m_rate_slot[k] = 0;
            m_oxy_slot[k] = 0;
        end
        m_index = 0; m_last_beat = 0; m_pointer = 0;
        m_rate_avg = 992; m_oxy_avg = 992;
    endfunction

    function automatic reading_t predict_reading(logic [17:0] red, logic [17:0] ir);
        reading_t r;
        logic signed [39:0] yr, yi;
        logic [31:0] interval, rate, avg;
        wide_t depth, ni, n2, n0;
        yr = filter_step(0, red);
        yi = filter_step(1, ir);
        interval = m_index - m_last_beat;
        depth = wide_t'(m_threshold) <<< 16;
        ni = yi; ni = -ni;
        n2 = y_hist[1][2]; n2 = -n2;
        n0 = y_hist[1][0]; n0 = -n0;
        r.beat = (ni >= depth) && (n2 > n0) && (n2 > ni) && (interval > 32'(m_min_interval));
        if (r.beat)
        begin
            rate = (32'd600 * 32'(m_rate_hz) + interval / 2) / interval;
            if (rate > 65535)
                rate = 65535;
            m_rate_slot[m_pointer] = rate[15:0];
            m_oxy_slot[m_pointer] = oxygen_estimate();
            m_pointer = (m_pointer + 1) % 5;
            m_last_beat = m_index;
            avg = slot_mean(m_rate_slot, 32'(m_hr_min), 32'(m_hr_max));
            m_rate_avg = avg[11:0];
            avg = slot_mean(m_oxy_slot, 32'(m_spo2_min), 32'(m_spo2_max));
            m_oxy_avg = avg[10:0];
        end
        m_index++;
        r.red = negated_integer(yr);
        r.ir = negated_integer(yi);
        r.rate = m_rate_avg;
        r.oxygen = m_oxy_avg;
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever
            #1 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(0, 99) < recv_idle);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        reading_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: red %0d ir %0d", red_filtered, ir_filtered);
            end
            else
            begin
                e = expected_readings.pop_front();
                if (e.red !== red_filtered || e.ir !== ir_filtered || e.beat !== beat_found
                    || e.rate !== heart_rate_tenths || e.oxygen !== spo2_tenths)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                                 e.red, e.ir, e.beat, e.rate, e.oxygen, red_filtered,
                                 ir_filtered, beat_found, heart_rate_tenths, spo2_tenths);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("pulse_oximeter_beat_processor test failed");
            $finish;
        end
    end

    task automatic send_item(logic [17:0] red, logic [17:0] ir);
        if ($urandom_range(0, 99) < send_idle)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle)
                @(posedge clk);
        end
        sample_valid <= 1'b1;
        red_sample <= red;
        ir_sample <= ir;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        expected_readings.push_back(predict_reading(red, ir));
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (expected_readings.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(pobp_pkg::reg_index_t idx, logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            pobp_pkg::REG_PEAK_THRESHOLD: m_threshold = value;
            pobp_pkg::REG_MIN_INTERVAL:   m_min_interval = value;
            pobp_pkg::REG_SAMPLE_RATE:    m_rate_hz = value[11:0];
            pobp_pkg::REG_HR_MIN:         m_hr_min = value[7:0];
            pobp_pkg::REG_HR_MAX:         m_hr_max = value[7:0];
            pobp_pkg::REG_SPO2_MIN:       m_spo2_min = value[6:0];
            pobp_pkg::REG_SPO2_MAX:       m_spo2_max = value[6:0];
            default: ;
        endcase
    endtask

    task automatic write_all(int thr, int gap, int hz, int hlo, int hhi, int slo, int shi);
        drain();
        write_reg(pobp_pkg::REG_PEAK_THRESHOLD, 16'(thr));
        write_reg(pobp_pkg::REG_MIN_INTERVAL, 16'(gap));
        write_reg(pobp_pkg::REG_SAMPLE_RATE, 16'(hz));
        write_reg(pobp_pkg::REG_HR_MIN, 16'(hlo));
        write_reg(pobp_pkg::REG_HR_MAX, 16'(hhi));
        write_reg(pobp_pkg::REG_SPO2_MIN, 16'(slo));
        write_reg(pobp_pkg::REG_SPO2_MAX, 16'(shi));
    endtask

    // Sawtooth pulse train with noise; the sharp fall gives one filtered peak per period.
    task automatic pulse_train(int count, bit red_dark, bit allow_noise);
        int period, amp, base, t, v, rv;
        period = $urandom_range(20, 150);
        amp = $urandom_range(1000, 60000);
        base = $urandom_range(20000, 150000);
        for (int n = 0; n < count; n++)
        begin
            if (allow_noise && $urandom_range(0, 99) < 12)
                send_item(18'($urandom_range(0, 262143)), 18'($urandom_range(0, 262143)));
            else
            begin
                t = n % period;
                v = base + amp * t / period + $urandom_range(0, amp / 20);
                rv = base / 2 + (amp / 3) * t / period + $urandom_range(0, amp / 40);
                if (v > 262143)
                    v = 262143;
                if (rv > 262143)
                    rv = 262143;
                send_item(red_dark ? 18'd0 : rv[17:0], v[17:0]);
            end
        end
    endtask

    task automatic test_extremes();
        send_item(18'd0, 18'd0);
        send_item(18'h3FFFF, 18'h3FFFF);
        send_item(18'd0, 18'h3FFFF);
        send_item(18'h3FFFF, 18'd0);
        send_item(18'h2AAAA, 18'h15555);
        send_item(18'h15555, 18'h2AAAA);
        for (int k = 0; k < 14; k++)
            send_item((k % 2) ? 18'h3FFFF : 18'd0, (k % 3) ? 18'd0 : 18'h3FFFF);
    endtask

    // Beats while the red channel is dark exercise the zero SpO2 divisor.
    task automatic test_dark_red();
        write_all(10, 0, 100, 40, 150, 50, 101);
        pulse_train(120, 1'b1, 1'b0);
    endtask

    task automatic test_backpressure();
        drain();
        send_idle = 0;
        recv_idle = 0;
        hold_request = 3000;
        pulse_train(60, 1'b0, 1'b0);
        // Sender pauses until everything sent so far has come back.
        sample_valid <= 1'b0;
        while (expected_readings.size() > 0)
            @(posedge clk);
        pulse_train(30, 1'b0, 1'b0);
    endtask

    task automatic test_settings();
        write_all(0, 0, 0, 40, 150, 50, 101);
        pulse_train(80, 1'b0, 1'b1);
        write_all(65535, 65535, 3200, 255, 255, 127, 127);
        pulse_train(50, 1'b0, 1'b1);
        write_all(0, 1, 3200, 0, 255, 0, 127);
        pulse_train(90, 1'b0, 1'b1);
        write_all(50, 10, 1, 200, 10, 127, 0);
        pulse_train(80, 1'b0, 1'b1);
        write_all(100, 50, 100, 40, 150, 50, 101);
    endtask

    task automatic test_random(int s_idle, int r_idle);
        send_idle = s_idle;
        recv_idle = r_idle;
        repeat (3)
        begin
            if ($urandom_range(0, 2) == 0)
                write_all($urandom_range(0, 400), $urandom_range(0, 60),
                          $urandom_range(1, 3200), $urandom_range(0, 80),
                          $urandom_range(100, 255), $urandom_range(0, 70),
                          $urandom_range(90, 127));
            pulse_train(52, 1'b0, 1'b1);
        end
    endtask

    initial
    begin
        rst_n = 0;
        sample_valid = 0;
        red_sample = 0;
        ir_sample = 0;
        cfg_write = 0;
        cfg_index = pobp_pkg::REG_PEAK_THRESHOLD;
        cfg_data = 0;
        predictor_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_dark_red();
        test_backpressure();
        test_settings();
        test_random(0, 0);
        test_random(84, 0);
        test_random(0, 84);
        test_random(34, 34);
        drain();
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("pulse_oximeter_beat_processor test passed");
        else
            $display("pulse_oximeter_beat_processor test failed");
        $finish;
    end
endmodule

/* files.f */
sv/pobp_pkg.sv
sv/pobp_mac.sv
sv/pobp_div.sv
sv/pulse_oximeter_beat_processor.sv
bench/pulse_oximeter_beat_processor_tb.sv
